// ----- rtl/rmjn_pkg.sv -----
// Shared types and constants for the recovery journal note parser.
// No dependencies; imported by the parser, the emitter and the top level.
package rmjn_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned NoteW   = 7;
  localparam int unsigned ChanW   = 4;
  localparam int unsigned LenW    = 10;
  localparam int unsigned ChCntW  = 5;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned Lanes   = 8;
  localparam int unsigned LaneW   = 3;

  localparam logic [3:0]      StatusHi   = 4'b1000;  // high nibble of note-off status
  localparam logic [LenW-1:0] MinChanLen = 10'd3;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_CHECK_HI = 4'd1,
    PH_CHECK_LO = 4'd2,
    PH_CH_HDR0  = 4'd3,
    PH_CH_HDR1  = 4'd4,
    PH_CH_TABLE = 4'd5,
    PH_N_HDR0   = 4'd6,
    PH_N_HDR1   = 4'd7,
    PH_LOG_NUM  = 4'd8,
    PH_LOG_VEL  = 4'd9,
    PH_BITMAP   = 4'd10,
    PH_SKIP     = 4'd11
  } phase_t;

  // Events raised by one journal byte. Lane j set means note base_note+j.
  typedef struct packed {
    logic [Lanes-1:0] mask;
    logic             is_on;
    logic [ChanW-1:0] channel;
    logic [NoteW-1:0] base_note;
    logic [NoteW-1:0] velocity;
  } group_t;

endpackage

// ----- rtl/rmjn_parser.sv -----
// Journal byte parser: phase register and per-byte decode into an event group.
// Depends on rmjn_pkg.
module rmjn_parser import rmjn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [ByteW-1:0] byte_in,
  input  logic             start,
  output group_t           group
);

  phase_t            phase_r, phase_nxt;
  logic [ChCntW-1:0] chans_r, chans_nxt;
  logic [ChanW-1:0]  chan_r, chan_nxt;
  logic [LenW-1:0]   left_r, left_nxt;
  logic [NoteW-1:0]  logs_r, logs_nxt;
  logic [NoteW-1:0]  held_r, held_nxt;
  logic [IdxW-1:0]   idx_r, idx_nxt;
  logic [IdxW-1:0]   last_r, last_nxt;
  logic              chn_r, chn_nxt;

  phase_t            next_ph;
  logic              counted;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   left_dec;
  logic [ChCntW-1:0] chans_dec;
  logic [NoteW-1:0]  logs_dec;
  logic [Lanes-1:0]  rev;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      chans_r <= '0;
      chan_r  <= '0;
      left_r  <= '0;
      logs_r  <= '0;
      held_r  <= '0;
      idx_r   <= '0;
      last_r  <= '0;
      chn_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      chans_r <= chans_nxt;
      chan_r  <= chan_nxt;
      left_r  <= left_nxt;
      logs_r  <= logs_nxt;
      held_r  <= held_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
      chn_r   <= chn_nxt;
    end
  end

  always_comb begin
    for (int j = 0; j < Lanes; j++) begin
      rev[j] = byte_in[Lanes-1-j];
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    chans_nxt = chans_r;
    chan_nxt  = chan_r;
    left_nxt  = left_r;
    logs_nxt  = logs_r;
    held_nxt  = held_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    chn_nxt   = chn_r;
    next_ph   = PH_SKIP;
    counted   = 1'b0;
    len       = left_r | {2'b00, byte_in};
    left_dec  = left_r - 1'b1;
    chans_dec = chans_r - 1'b1;
    logs_dec  = logs_r - 1'b1;
    group           = '0;
    group.channel   = chan_r;
    group.base_note = {idx_r, 3'b000};

    if (start) begin
      chans_nxt = byte_in[5] ? ({1'b0, byte_in[3:0]} + 1'b1) : '0;
      phase_nxt = PH_CHECK_HI;
    end else begin
      unique case (phase_r)
        PH_CHECK_HI: phase_nxt = PH_CHECK_LO;
        PH_CHECK_LO: phase_nxt = (chans_r != '0) ? PH_CH_HDR0 : PH_IDLE;
        PH_CH_HDR0: begin
          chan_nxt  = byte_in[6:3];
          left_nxt  = {byte_in[1:0], 8'h00};
          phase_nxt = PH_CH_HDR1;
        end
        PH_CH_HDR1: begin
          if (len < MinChanLen) len = MinChanLen;
          left_nxt  = len - 2'd2;
          phase_nxt = PH_CH_TABLE;
        end
        PH_CH_TABLE: begin
          counted = 1'b1;
          chn_nxt = byte_in[3] && (byte_in[7:4] == 4'h0);
          next_ph = chn_nxt ? PH_N_HDR0 : PH_SKIP;
        end
        PH_N_HDR0: begin
          counted  = 1'b1;
          logs_nxt = byte_in[6:0];
          next_ph  = PH_N_HDR1;
        end
        PH_N_HDR1: begin
          counted  = 1'b1;
          idx_nxt  = byte_in[7:4];
          last_nxt = byte_in[3:0];
          if (logs_r != '0) next_ph = PH_LOG_NUM;
          else next_ph = (byte_in[7:4] <= byte_in[3:0]) ? PH_BITMAP : PH_SKIP;
        end
        PH_LOG_NUM: begin
          counted  = 1'b1;
          held_nxt = byte_in[6:0];
          next_ph  = PH_LOG_VEL;
        end
        PH_LOG_VEL: begin
          counted  = 1'b1;
          if (byte_in[7]) begin
            group.mask      = 8'h01;
            group.is_on     = 1'b1;
            group.base_note = held_r;
            group.velocity  = byte_in[6:0];
          end
          logs_nxt = logs_dec;
          if (logs_dec != '0) next_ph = PH_LOG_NUM;
          else next_ph = (idx_r <= last_r) ? PH_BITMAP : PH_SKIP;
        end
        PH_BITMAP: begin
          counted    = 1'b1;
          group.mask = rev;
          if (idx_r >= last_r) begin
            next_ph = PH_SKIP;
          end else begin
            idx_nxt = idx_r + 1'b1;
            next_ph = PH_BITMAP;
          end
        end
        PH_SKIP: begin
          counted = 1'b1;
          next_ph = PH_SKIP;
        end
        default: phase_nxt = PH_IDLE;
      endcase

      // Bytes inside a channel journal count down its length.
      if (counted) begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          chans_nxt = chans_dec;
          phase_nxt = (chans_dec != '0) ? PH_CH_HDR0 : PH_IDLE;
        end else begin
          phase_nxt = next_ph;
        end
      end
    end
  end

endmodule

// ----- rtl/rmjn_emitter.sv -----
// Event serializer: holds one byte's event group and drains it one event
// per cycle into the output register unless stalled. Depends on rmjn_pkg.
module rmjn_emitter import rmjn_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  group_t           group,
  output logic             can_load,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [ByteW-1:0] out_status,
  output logic [NoteW-1:0] out_note,
  output logic [NoteW-1:0] out_vel,
  output logic             out_last
);

  logic [Lanes-1:0] mask_r, mask_nxt;
  logic             on_r;
  logic [ChanW-1:0] chan_r;
  logic [NoteW-1:0] base_r;
  logic [NoteW-1:0] vel_r;

  logic             valid_r, valid_nxt;
  logic [ByteW-1:0] status_r;
  logic [NoteW-1:0] note_r;
  logic [NoteW-1:0] ovel_r;
  logic             last_r;

  logic [Lanes-1:0] first;
  logic [LaneW-1:0] lane;
  logic [Lanes-1:0] rest;
  logic             out_free;
  logic             pop;

  // Lowest set lane goes out first.
  always_comb begin
    first = '0;
    lane  = '0;
    for (int j = Lanes - 1; j >= 0; j--) begin
      if (mask_r[j]) begin
        first = '0;
        first[j] = 1'b1;
        lane  = LaneW'(j);
      end
    end
  end

  assign rest     = mask_r & ~first;
  assign out_free = !valid_r || out_ready;
  assign pop      = out_free && (mask_r != '0);
  assign can_load = (mask_r == '0) || (out_free && (rest == '0));

  always_comb begin
    mask_nxt = pop ? rest : mask_r;
    if (load) mask_nxt = group.mask;
    valid_nxt = pop ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      mask_r  <= mask_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      on_r   <= group.is_on;
      chan_r <= group.channel;
      base_r <= group.base_note;
      vel_r  <= group.velocity;
    end
    if (pop) begin
      status_r <= {StatusHi[3:1], on_r, chan_r};
      note_r   <= base_r | {4'b0000, lane};
      ovel_r   <= vel_r;
      last_r   <= (rest == '0);
    end
  end

  assign out_valid  = valid_r;
  assign out_status = status_r;
  assign out_note   = note_r;
  assign out_vel    = ovel_r;
  assign out_last   = last_r;

endmodule

// ----- rtl/midi_recovery_journal_note_parser.sv -----
// Top level of the recovery journal chapter N note parser.
// Depends on rmjn_pkg, rmjn_parser and rmjn_emitter.
//
// Usage:
//   The input stream carries one recovery journal byte per request; in_tuser
//   flags the first byte (journal header) of a new journal and restarts the
//   parse at that byte. The output stream carries MIDI note events: status
//   (0x80/0x90 plus channel), note number and velocity; out_tlast marks the
//   last event that one journal byte produced.
//   Path: an accepted byte's events are loaded into the group holder;
//   from there each event in turn is registered in the output register.
//   Throughput: bytes that raise no event, and bytes raising one event, go
//   in one per cycle while out_tready stays high. A note-off bitmap
//   byte raises up to eight events and holds the input until its last
//   event leaves the holder, one event per cycle leaving the output
//   register while not stalled, as the emitter has a single drain port.
//   Stall: while out_tready is low the output register holds its event and
//   the group holder keeps the rest; in_tready drops once the holder cannot
//   take the next byte's events. Bytes are never lost.
//   Reset (rst_n low, synchronous): parser goes idle awaiting a journal
//   header, pending events are dropped, out_tvalid goes low.
module midi_recovery_journal_note_parser import rmjn_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] journal_byte
  input  logic        in_tuser,   // [0] journal_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] event_status, [14:8] note_number,
                                  // [21:15] velocity, [23:22] zero
  output logic        out_tlast   // last_of_run
);

  logic             accept;
  logic             can_load;
  group_t           group;
  logic [ByteW-1:0] status;
  logic [NoteW-1:0] note;
  logic [NoteW-1:0] vel;

  // Accept a byte whenever the holder will be free of the previous group.
  assign in_tready = can_load;
  assign accept    = in_tvalid && in_tready;

  rmjn_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .byte_in (in_tdata),
    .start   (in_tuser),
    .group   (group)
  );

  // Load only groups that carry events; eventless bytes leave the holder alone.
  rmjn_emitter u_emitter (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && (group.mask != '0)),
    .group      (group),
    .can_load   (can_load),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (status),
    .out_note   (note),
    .out_vel    (vel),
    .out_last   (out_tlast)
  );

  assign out_tdata = {2'b00, vel, note, status};

endmodule

// ----- rtl/rmjn_checker.sv -----
// Port-level checks for the note parser, bound to the top level.
// Depends only on the top level's ports.
module rmjn_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // Every event carries a note-on or note-off status.
  a_status_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:5] == 3'b100))
    else $error("event status is not a note-on or note-off");

  // Note-off events carry zero velocity.
  a_off_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[4]) |-> (out_tdata[21:15] == 7'd0))
    else $error("note-off with nonzero velocity");

  // Reset drops any pending event.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid right after reset");

  // A stalled event holds its content.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tlast)))
    else $error("stalled event changed");

endmodule

bind midi_recovery_journal_note_parser rmjn_checker u_rmjn_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
